/* rtl/core/upq_pkg.sv */
// upq_pkg: shared types and constants for the unsorted max priority queue
// used by upq_ctrl, upq_datapath and unsorted_max_priority_queue
// no dependencies
package upq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int PADDR_W   = 3;

  // register map: word index taken from paddr[2]
  localparam logic REG_SIGNED_KEYS = 1'b0;

  // request codes
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FILL,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted word
    logic exec;       // enqueue, or start of dequeue
    logic scan_read;  // read the next held entry
    logic fill;       // remove the maximum, move the last entry into its slot
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_deq;
    logic empty;
    logic scan_last;
  } dp_stat_t;

  // maps a key onto an unsigned scale that keeps the configured order
  function automatic logic [KEY_WIDTH-1:0] order_key(input logic [KEY_WIDTH-1:0] key,
                                                     input logic sgn);
    logic [KEY_WIDTH-1:0] flip;
    flip = '0;
    flip[KEY_WIDTH-1] = sgn;
    return key ^ flip;
  endfunction

endpackage

/* rtl/core/upq_ctrl.sv */
// upq_ctrl: sequencer for enqueue and dequeue-max requests
// depends on upq_pkg; drives upq_datapath through dp_cmd_t
module upq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_free,
  input  upq_pkg::dp_stat_t stat,
  output upq_pkg::dp_cmd_t  cmd,
  output logic             in_stall,
  output logic             out_load
);
  import upq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_deq && !stat.empty) state_next = ST_SCAN;
        else state_next = ST_RESULT;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
      end
      ST_RESULT: begin
        out_load = out_free;
      end
    endcase
  end

  // a scan read is only issued while the store holds entries
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_read |-> !stat.empty)
    else $error("scan read on empty store");

  // every last scan read is followed by a fill, with the drain state between them
  a_scan_to_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_read && stat.scan_last) |=> ##1 cmd.fill)
    else $error("scan did not end in fill");

  // a result is loaded only after the request was executed
  a_load_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_load) |-> ($past(cmd.exec) || $past(cmd.fill) || $past(state) == ST_RESULT))
    else $error("result loaded without work");

endmodule

/* rtl/core/upq_datapath.sv */
// upq_datapath: key store, held count, max scan and result registers
// depends on upq_pkg; commanded by upq_ctrl
module upq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  upq_pkg::dp_cmd_t   cmd,
  input  upq_pkg::in_word_t  item,
  input  logic               signed_keys,
  output upq_pkg::dp_stat_t  stat,
  output upq_pkg::out_word_t res
);
  import upq_pkg::*;

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic                 item_req;
  logic [KEY_WIDTH-1:0] item_key;
  logic [COUNT_W-1:0]   count;
  logic [ADDR_W-1:0]    rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 rd_valid;
  logic [ADDR_W-1:0]    rd_idx;
  logic [KEY_WIDTH-1:0] best_value;
  logic [ADDR_W-1:0]    best_idx;
  logic [KEY_WIDTH-1:0] res_value;
  status_t              res_status;

  logic                 full;
  logic [COUNT_W-1:0]   count_m1;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 take_new;

  assign full     = (count == COUNT_W'(CAPACITY));
  assign count_m1 = count - COUNT_W'(1);

  // status toward the controller
  assign stat.is_deq    = (item_req == REQ_DEQUEUE);
  assign stat.empty     = (count == '0);
  assign stat.scan_last = (rd_addr == count_m1[ADDR_W-1:0]);

  // single write port: append on enqueue, refill the hole on removal
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = item_key;
    if (cmd.exec && item_req == REQ_ENQUEUE && !full) begin
      wr_en = 1'b1;
    end else if (cmd.fill) begin
      // rd_data still holds the last held entry, read at the end of the scan
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (cmd.scan_read) rd_data <= mem[rd_addr];
  end

  // accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_req <= item.req_type;
      item_key <= item.key_value[KEY_WIDTH-1:0];
    end
  end

  // held count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec && item_req == REQ_ENQUEUE && !full) begin
      count <= count + COUNT_W'(1);
    end else if (cmd.fill) begin
      count <= count_m1;
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_addr <= '0;
    end else if (cmd.scan_read) begin
      rd_addr <= rd_addr + ADDR_W'(1);
      rd_idx  <= rd_addr;
    end
  end

  // running maximum, first strictly greater entry wins
  assign take_new = (rd_idx == '0) ||
                    (order_key(rd_data, signed_keys) > order_key(best_value, signed_keys));

  always_ff @(posedge clk) begin
    if (rd_valid && take_new) begin
      best_value <= rd_data;
      best_idx   <= rd_idx;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_value <= '0;
      if (item_req == REQ_ENQUEUE) begin
        res_status <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        res_status <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
      end
    end else if (cmd.fill) begin
      res_value  <= best_value;
      res_status <= STATUS_OK;
    end
  end

  assign res.out_value   = 32'(res_value);
  assign res.status      = res_status;
  assign res.entry_count = 7'(count);

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("held count above capacity");

  // removal lowers the count by one
  a_fill_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |=> count == $past(count_m1))
    else $error("removal did not lower count");

  // accepted enqueue below capacity raises the count by one
  a_enq_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && item_req == REQ_ENQUEUE && !full) |=> count == $past(count) + COUNT_W'(1))
    else $error("enqueue did not raise count");

endmodule

/* rtl/core/unsorted_max_priority_queue.sv */
// unsorted_max_priority_queue: top level, config register and output register
// depends on upq_pkg, upq_ctrl, upq_datapath
//
//   port group   dir   carries
//   in_*         in    in_word_t request word (req_type, key_value)
//   out_*        out   out_word_t result word (out_value, status, entry_count)
//   p*           io    APB-style config, signed_keys at byte address 0
//
// enqueue: the accepted word passes the exec and result states into the output register
// dequeue with n held entries: exec, a scan of all n entries, drain, fill and result;
//   the scan reads one entry per cycle through the single read port of the key store
// the next word is accepted once the result is in the output register
// rst (synchronous) empties the queue and clears signed_keys
// out_stall holds the result; a further result waits in the controller
module unsorted_max_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  upq_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output upq_pkg::out_word_t            out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upq_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import upq_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t res;
  logic      out_load;
  logic      out_free;
  logic      signed_keys;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_keys <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SIGNED_KEYS) begin
      signed_keys <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SIGNED_KEYS) ? {31'b0, signed_keys} : 32'b0;

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_word <= res;
  end

  upq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall),
    .out_load (out_load)
  );

  upq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (in_word),
    .signed_keys (signed_keys),
    .stat        (stat),
    .res         (res)
  );

endmodule
